// File: rtl/core/rpm_pkg.sv
// ----------------------------------------------------------------------------
// rpm_pkg
// shared types and constants of the rc pwm pulse width mapper
// ----------------------------------------------------------------------------
package rpm_pkg;

    localparam int NumChannels = 2;
    localparam int TickW       = 32;
    localparam int ValW        = 32;
    localparam int CfgIdxW     = 3;
    localparam int QueueDepth  = 2;
    localparam int MapChannels = 2;

    localparam logic [TickW-1:0] LegalLowReset  = 32'd42000;
    localparam logic [TickW-1:0] FullLowReset   = 32'd84000;
    localparam logic [TickW-1:0] FullHighReset  = 32'd168000;
    localparam logic [TickW-1:0] LegalHighReset = 32'd210000;
    localparam logic [ValW-1:0]  MapMinReset    = 32'd0;
    localparam logic [ValW-1:0]  MapMaxReset    = 32'd65536;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LEGAL_LOW  = 3'd0,
        CFG_FULL_LOW   = 3'd1,
        CFG_FULL_HIGH  = 3'd2,
        CFG_LEGAL_HIGH = 3'd3,
        CFG_MAP_MIN0   = 3'd4,
        CFG_MAP_MAX0   = 3'd5,
        CFG_MAP_MIN1   = 3'd6,
        CFG_MAP_MAX1   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic             channel;
        logic [TickW-1:0] capture_time;
        logic             pin_level;
    } t_in_item;

    typedef struct packed {
        logic                   out_channel;
        logic [TickW-1:0]       pulse_ticks;
        logic signed [ValW-1:0] mapped_value;
    } t_out_item;

    typedef struct packed {
        logic [TickW-1:0]                   legal_low;
        logic [TickW-1:0]                   full_low;
        logic [TickW-1:0]                   full_high;
        logic [TickW-1:0]                   legal_high;
        logic [MapChannels-1:0][ValW-1:0]   map_min;
        logic [MapChannels-1:0][ValW-1:0]   map_max;
    } t_cfg;

    typedef struct packed {
        logic             channel;
        logic [TickW-1:0] ticks;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL,
        BK_DIV,
        BK_ADD
    } t_back_state;

endpackage

// File: rtl/core/rpm_cfg.sv
// ----------------------------------------------------------------------------
// rpm_cfg
// configuration register file, written over a valid/ready channel
// ----------------------------------------------------------------------------
module rpm_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rpm_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [rpm_pkg::ValW-1:0]    i_cfg_data,
    output rpm_pkg::t_cfg               o_cfg
);
    import rpm_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.legal_low  <= LegalLowReset;
            r_cfg.full_low   <= FullLowReset;
            r_cfg.full_high  <= FullHighReset;
            r_cfg.legal_high <= LegalHighReset;
            r_cfg.map_min    <= {MapChannels{MapMinReset}};
            r_cfg.map_max    <= {MapChannels{MapMaxReset}};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEGAL_LOW:  r_cfg.legal_low  <= i_cfg_data;
                CFG_FULL_LOW:   r_cfg.full_low   <= i_cfg_data;
                CFG_FULL_HIGH:  r_cfg.full_high  <= i_cfg_data;
                CFG_LEGAL_HIGH: r_cfg.legal_high <= i_cfg_data;
                CFG_MAP_MIN0:   r_cfg.map_min[0] <= i_cfg_data;
                CFG_MAP_MAX0:   r_cfg.map_max[0] <= i_cfg_data;
                CFG_MAP_MIN1:   r_cfg.map_min[1] <= i_cfg_data;
                CFG_MAP_MAX1:   r_cfg.map_max[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/rpm_front.sv
// ----------------------------------------------------------------------------
// rpm_front
// per-channel edge tracking, high time measurement, window check and clamp
// ----------------------------------------------------------------------------
module rpm_front #(
    parameter int NUM_CHANNELS = rpm_pkg::NumChannels
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rpm_pkg::t_in_item i_in,
    input  rpm_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output rpm_pkg::t_job     o_job
);
    import rpm_pkg::*;

    logic [TickW-1:0] r_last_time  [NUM_CHANNELS];
    logic             r_last_level [NUM_CHANNELS];
    logic             r_sample_ok  [NUM_CHANNELS];

    logic [NUM_CHANNELS-1:0] hit_ch;
    logic                    present;
    logic                    accept;
    logic [TickW-1:0]        sel_time;
    logic                    sel_level;
    logic                    sel_ok;
    logic [TickW-1:0]        width;
    logic [TickW-1:0]        raised;
    logic                    legal;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        sel_time  = '0;
        sel_level = 1'b0;
        sel_ok    = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            hit_ch[i] = ({31'b0, i_in.channel} == 32'(i));
            if (hit_ch[i]) begin
                sel_time  = r_last_time[i];
                sel_level = r_last_level[i];
                sel_ok    = r_sample_ok[i];
            end
        end
        present = |hit_ch;
    end

    assign width  = i_in.capture_time - sel_time;
    assign legal  = !(width < i_cfg.legal_low || width > i_cfg.legal_high);
    assign raised = (width < i_cfg.full_low) ? i_cfg.full_low : width;

    assign o_push = accept && present && sel_ok && sel_level && !i_in.pin_level && legal;
    assign o_job.channel = i_in.channel;
    assign o_job.ticks   = (raised > i_cfg.full_high) ? i_cfg.full_high : raised;

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_last_time[g]  <= '0;
                r_last_level[g] <= 1'b0;
                r_sample_ok[g]  <= 1'b0;
            end else if (accept && hit_ch[g]) begin
                r_last_time[g]  <= i_in.capture_time;
                r_last_level[g] <= i_in.pin_level;
                r_sample_ok[g]  <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rpm_queue.sv
// ----------------------------------------------------------------------------
// rpm_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
module rpm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpm_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_nonempty,
    input  logic          i_pop,
    output rpm_pkg::t_job o_job
);
    import rpm_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);

    t_job            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full     = (r_cnt == CntW'(QueueDepth));
    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rpm_back.sv
// ----------------------------------------------------------------------------
// rpm_back
// linear map of the clamped high time: multiply, bit-serial divide, offset
// ----------------------------------------------------------------------------
module rpm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  rpm_pkg::t_job      i_job,
    output logic               o_pop,
    input  rpm_pkg::t_cfg      i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rpm_pkg::t_out_item o_out
);
    import rpm_pkg::*;

    localparam int CntW = $clog2(TickW);

    t_back_state r_state;
    t_back_state n_state;

    logic             r_ch;
    logic [TickW-1:0] r_ticks;
    logic [TickW-1:0] r_span;
    logic [TickW-1:0] r_off;
    logic [ValW-1:0]  r_lo;
    logic             r_neg;
    logic [ValW-1:0]  r_mag;
    logic             r_zero;
    logic [TickW-1:0] r_rem;
    logic [TickW-1:0] r_quo;
    logic [CntW-1:0]  r_cnt;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [ValW:0]      diff;
    logic [ValW:0]      diff_abs;
    logic [2*TickW-1:0] prod;
    logic [TickW:0]     rem_shift;
    logic [TickW:0]     rem_sub;
    logic               rem_ge;
    logic               out_free;
    logic [ValW-1:0]    mapped;

    assign diff      = {i_cfg.map_max[r_ch][ValW-1], i_cfg.map_max[r_ch]}
                     - {i_cfg.map_min[r_ch][ValW-1], i_cfg.map_min[r_ch]};
    assign diff_abs  = diff[ValW] ? (~diff + 1'b1) : diff;
    assign prod      = r_off * r_mag;
    assign rem_shift = {r_rem, r_quo[TickW-1]};
    assign rem_sub   = rem_shift - {1'b0, r_span};
    assign rem_ge    = (rem_shift >= {1'b0, r_span});
    assign out_free  = !r_out_valid || !i_out_stall;
    assign mapped    = r_zero ? r_lo : (r_neg ? (r_lo - r_quo) : (r_lo + r_quo));

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_PREP;
                end
            end
            BK_PREP: n_state = BK_MUL;
            BK_MUL:  n_state = BK_DIV;
            BK_DIV: begin
                if (r_cnt == CntW'(TickW - 1)) begin
                    n_state = BK_ADD;
                end
            end
            BK_ADD: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_ch    <= i_job.channel;
                r_ticks <= i_job.ticks;
            end
            BK_PREP: begin
                r_span <= i_cfg.full_high - i_cfg.full_low;
                r_off  <= r_ticks - i_cfg.full_low;
                r_zero <= (i_cfg.full_high <= i_cfg.full_low);
                r_lo   <= i_cfg.map_min[r_ch];
                r_neg  <= diff[ValW];
                r_mag  <= diff_abs[ValW-1:0];
            end
            BK_MUL: begin
                r_rem <= prod[2*TickW-1:TickW];
                r_quo <= prod[TickW-1:0];
                r_cnt <= '0;
            end
            BK_DIV: begin
                r_rem <= rem_ge ? rem_sub[TickW-1:0] : rem_shift[TickW-1:0];
                r_quo <= {r_quo[TickW-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            BK_ADD: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_ADD && out_free) begin
            r_out.out_channel  <= r_ch;
            r_out.pulse_ticks  <= r_ticks;
            r_out.mapped_value <= mapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == BK_ADD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/core/rc_pwm_pulse_width_mapper_unit.sv
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_mapper_unit
// rc servo pulse width decoder with linear map to a signed q16.16 command
// ----------------------------------------------------------------------------
// channel   direction  handshake            beat
// in        input      i_in_valid/o_in_stall capture edge: channel, time, level
// out       output     o_out_valid/i_out_stall decoded pulse: channel, ticks, value
// cfg       input      i_cfg_valid/o_cfg_ready register index and 32-bit data
//
// an edge is taken in one cycle unless the two-entry job queue is full
// each decoded pulse passes the back part states prep, multiply, the
// bit-serial 32-step divide and add, one job at a time; add waits for a free output
// edges that give no pulse never reach the back part
// synchronous active-low reset clears channel history, queue and output
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_mapper_unit #(
    parameter int NUM_CHANNELS = rpm_pkg::NumChannels
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rpm_pkg::t_in_item           i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rpm_pkg::t_out_item          o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rpm_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [rpm_pkg::ValW-1:0]    i_cfg_data
);
    import rpm_pkg::*;

    t_cfg cfg;
    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_nonempty;

    rpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpm_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_cfg      (cfg),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    rpm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .i_pop      (pop),
        .o_job      (pop_job)
    );

    rpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_nonempty),
        .i_job       (pop_job),
        .o_pop       (pop),
        .i_cfg       (cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// File: rtl/core/rpm_checker.sv
// ----------------------------------------------------------------------------
// rpm_checker
// port-level checks of the pulse width mapper, bound to the top level
// ----------------------------------------------------------------------------
module rpm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rpm_pkg::t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("output payload changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

endmodule

bind rc_pwm_pulse_width_mapper_unit rpm_checker u_rpm_checker (.*);
